[hw/rtl/point_in_convex_polygon_unit_defines.svh]
// Assertion macros for the convex polygon containment unit.
// Used by the checker module; no other dependencies.
`ifndef POINT_IN_CONVEX_POLYGON_UNIT_DEFINES_SVH
`define POINT_IN_CONVEX_POLYGON_UNIT_DEFINES_SVH

// Property checked while reset is low.
`define PIC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Property checked at every edge, reset included.
`define PIC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

[hw/rtl/pic_pkg.sv]
// Shared constants and control types of the convex polygon containment unit.
// No dependencies.
package pic_pkg;

   localparam int MAX_VERTICES = 16;
   localparam int ADDR_W       = $clog2(MAX_VERTICES);
   localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
   localparam int IDX_W        = 4;
   localparam int CFG_W        = 5;
   localparam int COORD_W      = 16;
   localparam int DIFF_W       = COORD_W + 1;
   localparam int PROD_W       = 2 * DIFF_W;
   localparam int VERTEX_W     = 2 * COORD_W;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic valid;
      logic closes_edge;
      logic first_edge;
      logic last_edge;
   } walk_tag_type;

   typedef struct packed {
      logic              wr_en;
      logic              load_point;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      walk_tag_type      tag;
      logic              res_take;
   } cmd_type;

   typedef struct packed {
      logic res_valid;
   } status_type;

endpackage

[hw/rtl/pic_req_if.sv]
// Request channel: vertex write or point query, valid/ready handshake.
// Depends on pic_pkg.
interface pic_req_if;
   logic                          valid;
   logic                          ready;
   logic                          operation;
   logic [pic_pkg::IDX_W-1:0]     vertex_index;
   logic signed [pic_pkg::COORD_W-1:0] coord_x;
   logic signed [pic_pkg::COORD_W-1:0] coord_z;

   modport source (output valid, operation, vertex_index, coord_x, coord_z, input ready);
   modport sink   (input valid, operation, vertex_index, coord_x, coord_z, output ready);
endinterface

[hw/rtl/pic_rsp_if.sv]
// Response channel: containment result, valid/ready handshake.
// No dependencies.
interface pic_rsp_if;
   logic valid;
   logic ready;
   logic inside_res;

   modport source (output valid, inside_res, input ready);
   modport sink   (input valid, inside_res, output ready);
endinterface

[hw/rtl/pic_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pic_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/pic_ctrl.sv]
// Controller: handshakes, vertex count register and the edge walk sequencer.
// Depends on pic_pkg.
module pic_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_operation,
   input  logic [pic_pkg::IDX_W-1:0]  req_vertex_index,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic                       csr_wr_en,
   input  logic [pic_pkg::CFG_W-1:0]  csr_wr_data,
   output pic_pkg::cmd_type           cmd,
   input  pic_pkg::status_type        status
);

   typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_WAIT} state_type;

   state_type                   state_ff, state_in;
   logic [pic_pkg::CNT_W-1:0]   step_ff, step_in;
   logic [pic_pkg::CFG_W-1:0]   count_ff, count_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [pic_pkg::CNT_W-1:0]   n_eff;
   logic                        req_xfer;
   logic                        at_last;

   // vertex count clamped to [2, MAX_VERTICES]
   always_comb begin
      if (32'(count_ff) > 32'(pic_pkg::MAX_VERTICES)) begin
         n_eff = pic_pkg::CNT_W'(pic_pkg::MAX_VERTICES);
      end else if (count_ff < pic_pkg::CFG_W'(2)) begin
         n_eff = pic_pkg::CNT_W'(2);
      end else begin
         n_eff = pic_pkg::CNT_W'(count_ff);
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign at_last   = (step_ff == n_eff);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.wr_en      = req_xfer && (req_operation == pic_pkg::OP_WRITE)
                       && (32'(req_vertex_index) < 32'(pic_pkg::MAX_VERTICES));
      cmd.load_point = req_xfer && (req_operation == pic_pkg::OP_QUERY);
      cmd.rd_en      = (state_ff == ST_WALK);
      cmd.rd_addr    = at_last ? '0 : step_ff[pic_pkg::ADDR_W-1:0];
      cmd.tag.valid       = (state_ff == ST_WALK);
      cmd.tag.closes_edge = (step_ff != '0);
      cmd.tag.first_edge  = (step_ff == pic_pkg::CNT_W'(1));
      cmd.tag.last_edge   = at_last;
      cmd.res_take   = (state_ff == ST_WAIT) && status.res_valid
                       && (!rsp_valid_ff || rsp_ready);
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      count_in     = csr_wr_en ? csr_wr_data : count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.load_point) begin
               step_in  = '0;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            step_in = step_ff + pic_pkg::CNT_W'(1);
            if (at_last) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (cmd.res_take) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         count_ff     <= pic_pkg::CFG_W'(4);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[hw/rtl/pic_datapath.sv]
// Datapath: vertex store, edge difference/product/sign pipeline, result registers.
// Depends on pic_pkg and pic_ram.
module pic_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  pic_pkg::cmd_type                  cmd,
   output pic_pkg::status_type               status,
   input  logic [pic_pkg::IDX_W-1:0]         req_vertex_index,
   input  logic signed [pic_pkg::COORD_W-1:0] req_coord_x,
   input  logic signed [pic_pkg::COORD_W-1:0] req_coord_z,
   output logic                              rsp_inside_res
);

   logic [pic_pkg::VERTEX_W-1:0]              rd_data;
   logic signed [pic_pkg::COORD_W-1:0]        px_ff, pz_ff;
   logic signed [pic_pkg::COORD_W-1:0]        vx, vz;
   logic signed [pic_pkg::DIFF_W-1:0]         dx_in, dz_in;
   logic signed [pic_pkg::DIFF_W-1:0]         cur_dx_ff, cur_dz_ff, prev_dx_ff, prev_dz_ff;
   logic signed [pic_pkg::PROD_W-1:0]         prod_a_ff, prod_b_ff;
   pic_pkg::walk_tag_type                     tag1_ff, tag2_ff, tag3_ff;
   logic                                      sign;
   logic                                      first_sign_ff;
   logic                                      mismatch_ff;
   logic                                      res_valid_ff;
   logic                                      result_ff;
   logic                                      inside_ff;
   logic                                      edge_bad;

   pic_ram #(
      .WIDTH (pic_pkg::VERTEX_W),
      .DEPTH (pic_pkg::MAX_VERTICES)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (pic_pkg::ADDR_W'(req_vertex_index)),
      .wr_data ({req_coord_x, req_coord_z}),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_addr),
      .rd_data (rd_data)
   );

   assign vx    = rd_data[pic_pkg::VERTEX_W-1:pic_pkg::COORD_W];
   assign vz    = rd_data[pic_pkg::COORD_W-1:0];
   assign dx_in = {vx[pic_pkg::COORD_W-1], vx} - {px_ff[pic_pkg::COORD_W-1], px_ff};
   assign dz_in = {vz[pic_pkg::COORD_W-1], vz} - {pz_ff[pic_pkg::COORD_W-1], pz_ff};

   // +1 edge when nz*cx < cz*nx (c = previous vertex, n = current)
   assign sign     = (prod_a_ff < prod_b_ff);
   assign edge_bad = (sign != first_sign_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_point) begin
         px_ff <= req_coord_x;
         pz_ff <= req_coord_z;
      end
      if (tag1_ff.valid) begin
         cur_dx_ff  <= dx_in;
         cur_dz_ff  <= dz_in;
         prev_dx_ff <= cur_dx_ff;
         prev_dz_ff <= cur_dz_ff;
      end
      if (tag2_ff.valid) begin
         prod_a_ff <= cur_dz_ff * prev_dx_ff;
         prod_b_ff <= prev_dz_ff * cur_dx_ff;
      end
      if (tag3_ff.valid && tag3_ff.closes_edge) begin
         if (tag3_ff.first_edge) begin
            first_sign_ff <= sign;
         end
         if (tag3_ff.last_edge) begin
            result_ff <= !(mismatch_ff || edge_bad);
         end
      end
      if (cmd.res_take) begin
         inside_ff <= result_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff      <= '0;
         tag2_ff      <= '0;
         tag3_ff      <= '0;
         mismatch_ff  <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         tag1_ff <= cmd.tag;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
         if (tag3_ff.valid && tag3_ff.closes_edge) begin
            if (tag3_ff.first_edge) begin
               mismatch_ff <= 1'b0;
            end else begin
               mismatch_ff <= mismatch_ff || edge_bad;
            end
         end
         if (tag3_ff.valid && tag3_ff.last_edge) begin
            res_valid_ff <= 1'b1;
         end else if (cmd.res_take) begin
            res_valid_ff <= 1'b0;
         end
      end
   end

   assign status.res_valid = res_valid_ff;
   assign rsp_inside_res   = inside_ff;

endmodule

[hw/rtl/point_in_convex_polygon_unit.sv]
// Top level of the convex polygon containment unit.
// Depends on pic_pkg, pic_req_if, pic_rsp_if, pic_ctrl, pic_datapath.
//
//  channel  dir  handshake          payload
//  req_ch   in   valid/ready        operation, vertex_index, coord_x, coord_z
//  rsp_ch   out  valid/ready        inside_res
//  csr      in   csr_wr_en          csr_wr_data (vertex_count)
//
// After its accept a query walks n+1 store reads, n = vertex_count clamped to 2..16,
// then passes the difference, product and sign pipeline registers and the response
// register.
// Reset is synchronous; vertex_count resets to 4, the store is not cleared.
// A query result waits in the response register; the next request is taken
// meanwhile, and a query stalls at its end until the response register frees.
module point_in_convex_polygon_unit (
   input  logic                      clock,
   input  logic                      reset,
   pic_req_if.sink                   req_ch,
   pic_rsp_if.source                 rsp_ch,
   input  logic                      csr_wr_en,
   input  logic [pic_pkg::CFG_W-1:0] csr_wr_data
);

   pic_pkg::cmd_type    cmd;
   pic_pkg::status_type status;

   pic_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_ch.valid),
      .req_ready        (req_ch.ready),
      .req_operation    (req_ch.operation),
      .req_vertex_index (req_ch.vertex_index),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .cmd              (cmd),
      .status           (status)
   );

   pic_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_vertex_index (req_ch.vertex_index),
      .req_coord_x      (req_ch.coord_x),
      .req_coord_z      (req_ch.coord_z),
      .rsp_inside_res   (rsp_ch.inside_res)
   );

endmodule

[hw/rtl/pic_checker.sv]
// Port-level checks of the convex polygon containment unit, bound to the top level.
// Depends on pic_pkg and point_in_convex_polygon_unit_defines.svh.
`include "point_in_convex_polygon_unit_defines.svh"

module pic_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_operation,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_inside_res
);

   `PIC_ASSERT_ALWAYS(a_reset_no_rsp, clock, reset |=> !rsp_valid, "response valid after reset")
   `PIC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_inside_res), "stalled response changed")
   `PIC_ASSERT(a_query_busy, clock, reset, req_valid && req_ready && (req_operation == pic_pkg::OP_QUERY) |=> !req_ready, "request taken during a query walk")
   `PIC_ASSERT(a_no_early_rsp, clock, reset, req_valid && req_ready && !rsp_valid |=> !rsp_valid, "response without a finished query")

endmodule

bind point_in_convex_polygon_unit pic_checker u_pic_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .req_operation  (req_ch.operation),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_inside_res (rsp_ch.inside_res)
);

[sim/point_in_convex_polygon_unit_tb.sv]
`timescale 1ns / 1ps
// Testbench of point_in_convex_polygon_unit: a directed table, then random polygon phases.
// Response transfers are checked in order against a containment predictor or a fixed value.
// Depends on pic_pkg, pic_req_if, pic_rsp_if and the unit itself.
module point_in_convex_polygon_unit_tb;
   import pic_pkg::*;

   localparam int ITEM_TARGET  = 1750;
   localparam int QUIET_ITEMS  = 250;
   localparam int DRAIN_CYCLES = 30;
   localparam int MAX_BURST    = 12;

   typedef enum logic {STEP_ITEM, STEP_CSR} step_kind_e;
   typedef enum logic [1:0] {CHECK_PREDICTED, CHECK_OUTSIDE, CHECK_INSIDE} check_e;

   typedef struct packed {
      step_kind_e                kind;
      logic                      op;
      logic [IDX_W-1:0]          idx;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] z;
      check_e                    chk;
      logic [CFG_W-1:0]          count;
   } step_t;

   logic                      clock            = 1'b0;
   logic                      reset            = 1'b1;
   logic                      req_valid        = 1'b0;
   logic                      req_operation    = OP_WRITE;
   logic [IDX_W-1:0]          req_vertex_index = '0;
   logic signed [COORD_W-1:0] req_coord_x      = '0;
   logic signed [COORD_W-1:0] req_coord_z      = '0;
   logic                      rsp_ready        = 1'b0;
   logic                      csr_wr_en        = 1'b0;
   logic [CFG_W-1:0]          csr_wr_data      = '0;

   pic_req_if req_if ();
   pic_rsp_if rsp_if ();

   assign req_if.valid        = req_valid;
   assign req_if.operation    = req_operation;
   assign req_if.vertex_index = req_vertex_index;
   assign req_if.coord_x      = req_coord_x;
   assign req_if.coord_z      = req_coord_z;
   assign rsp_if.ready        = rsp_ready;

   point_in_convex_polygon_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   logic signed [COORD_W-1:0] vertex_x [MAX_VERTICES];
   logic signed [COORD_W-1:0] vertex_z [MAX_VERTICES];
   logic [CFG_W-1:0]          count_setting = CFG_W'(4);
   logic                      inside_expected [$];
   step_t                     steps [$];
   logic                      inside_want;
   int                        errors        = 0;
   int                        items_sent    = 0;
   int                        send_idle_pct = 0;
   int                        rsp_stall_pct = 0;
   int                        stall_left    = 0;
   int                        count_extremes [7] = '{31, 0, 16, 3, 1, 2, 17};

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("[point_in_convex_polygon_unit] ERROR");
      $finish;
   end

   function automatic int used_vertices(logic [CFG_W-1:0] setting);
      int n;
      n = setting;
      if (n > MAX_VERTICES) n = MAX_VERTICES;
      if (n < 2) n = 2;
      return n;
   endfunction

   // positive orientation: (nz-pz)*(cx-px) < (cz-pz)*(nx-px), exact at 17/34 bits
   function automatic bit edge_positive(int c, int n, logic signed [COORD_W-1:0] px,
                                        logic signed [COORD_W-1:0] pz);
      logic signed [DIFF_W-1:0] dcx, dcz, dnx, dnz;
      logic signed [PROD_W-1:0] lhs, rhs;
      dcx = vertex_x[c] - px;
      dcz = vertex_z[c] - pz;
      dnx = vertex_x[n] - px;
      dnz = vertex_z[n] - pz;
      lhs = dnz * dcx;
      rhs = dcz * dnx;
      return lhs < rhs;
   endfunction

   function automatic logic predict_inside(logic signed [COORD_W-1:0] px,
                                           logic signed [COORD_W-1:0] pz);
      int n, e;
      bit first;
      n = used_vertices(count_setting);
      first = edge_positive(0, 1, px, pz);
      for (e = 1; e < n; e++)
         if (edge_positive(e, (e + 1 == n) ? 0 : e + 1, px, pz) != first) return 1'b0;
      return 1'b1;
   endfunction

   function automatic logic signed [COORD_W-1:0] to_coord(int v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return COORD_W'(v);
   endfunction

   task automatic add_item(logic op, int idx, int x, int z, check_e chk);
      step_t s;
      s = '0;
      s.kind = STEP_ITEM;
      s.op   = op;
      s.idx  = IDX_W'(idx);
      s.x    = COORD_W'(x);
      s.z    = COORD_W'(z);
      s.chk  = chk;
      steps.push_back(s);
   endtask

   task automatic add_csr(int v);
      step_t s;
      s = '0;
      s.kind  = STEP_CSR;
      s.count = CFG_W'(v);
      steps.push_back(s);
   endtask

   task automatic send_item(logic op, logic [IDX_W-1:0] idx, logic signed [COORD_W-1:0] x,
                            logic signed [COORD_W-1:0] z, check_e chk);
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_vertex_index <= idx;
      req_coord_x      <= x;
      req_coord_z      <= z;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      items_sent++;
      if (op == OP_WRITE) begin
         vertex_x[idx] = x;
         vertex_z[idx] = z;
      end else begin
         case (chk)
            CHECK_INSIDE:  inside_expected.push_back(1'b1);
            CHECK_OUTSIDE: inside_expected.push_back(1'b0);
            default:       inside_expected.push_back(predict_inside(x, z));
         endcase
      end
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, MAX_BURST)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (inside_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_count(logic [CFG_W-1:0] v);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en     <= 1'b0;
      count_setting = v;
   endtask

   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (rsp_stall_pct != 0 && $urandom_range(99) < rsp_stall_pct) begin
         stall_left <= $urandom_range(MAX_BURST - 1);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (inside_expected.size() == 0) begin
            $error("inside_res: expected no transfer, actual %0d", rsp_if.inside_res);
            errors++;
         end else begin
            inside_want = inside_expected.pop_front();
            if (rsp_if.inside_res !== inside_want) begin
               $error("inside_res: expected %0d, actual %0d", inside_want, rsp_if.inside_res);
               errors++;
            end
         end
      end
   end

   initial begin
      int  base, phase, n, k, hw, hh, cx, cz, wid, hgt, per, stride, pos, j, len, q, r;
      int  mx, mz, px, pz;
      bit  rev;
      logic [CFG_W-1:0] v;

      // square at the reset count, then full-scale corners
      add_item(OP_WRITE, 0, -100, -100, CHECK_PREDICTED);
      add_item(OP_WRITE, 1, 100, -100, CHECK_PREDICTED);
      add_item(OP_WRITE, 2, 100, 100, CHECK_PREDICTED);
      add_item(OP_WRITE, 3, -100, 100, CHECK_PREDICTED);
      add_item(OP_QUERY, 0, 0, 0, CHECK_INSIDE);
      add_item(OP_QUERY, 15, 200, 0, CHECK_OUTSIDE);
      add_item(OP_QUERY, 5, 100, 0, CHECK_PREDICTED);
      add_item(OP_QUERY, 10, -100, -100, CHECK_PREDICTED);
      add_item(OP_WRITE, 0, -32768, -32768, CHECK_PREDICTED);
      add_item(OP_WRITE, 1, 32767, -32768, CHECK_PREDICTED);
      add_item(OP_WRITE, 2, 32767, 32767, CHECK_PREDICTED);
      add_item(OP_WRITE, 3, -32768, 32767, CHECK_PREDICTED);
      add_item(OP_QUERY, 0, 0, 0, CHECK_PREDICTED);
      add_item(OP_QUERY, 0, 32767, 32767, CHECK_PREDICTED);
      add_item(OP_QUERY, 0, -32768, -32768, CHECK_PREDICTED);
      add_item(OP_QUERY, 0, -32768, 32767, CHECK_PREDICTED);
      add_item(OP_WRITE, 15, -1, -1, CHECK_PREDICTED);
      add_csr(3);
      add_item(OP_QUERY, 0, 0, 0, CHECK_PREDICTED);
      add_item(OP_QUERY, 0, 32767, -32768, CHECK_PREDICTED);
      // count at or below the minimum walks the first two vertices
      add_csr(2);
      add_item(OP_QUERY, 0, 0, 0, CHECK_PREDICTED);
      add_csr(0);
      add_item(OP_QUERY, 0, 5, -7, CHECK_PREDICTED);
      add_item(OP_WRITE, 0, 0, 0, CHECK_PREDICTED);
      add_item(OP_WRITE, 1, 0, 0, CHECK_PREDICTED);
      add_csr(1);
      add_item(OP_QUERY, 0, 1, 1, CHECK_INSIDE);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 20;
      rsp_stall_pct = 20;
      foreach (steps[i]) begin
         if (steps[i].kind == STEP_CSR)
            write_count(steps[i].count);
         else
            send_item(steps[i].op, steps[i].idx, steps[i].x, steps[i].z, steps[i].chk);
      end

      base  = items_sent;
      phase = 0;
      while (items_sent < base + ITEM_TARGET) begin
         if (phase < 7) v = CFG_W'(count_extremes[phase]);
         else v = CFG_W'($urandom_range(31));
         write_count(v);
         n = used_vertices(v);
         k = $urandom_range(2);
         send_idle_pct = (k == 0) ? 0 : (k == 1) ? 10 : 35;
         k = $urandom_range(2);
         rsp_stall_pct = (k == 0) ? 0 : (k == 1) ? 10 : 35;
         if (items_sent >= base + ITEM_TARGET - QUIET_ITEMS) begin
            send_idle_pct = 0;
            rsp_stall_pct = 0;
         end

         // convex polygon: ordered points on the boundary of a random rectangle
         hw  = ($urandom_range(3) == 0) ? $urandom_range(4, 16383) : $urandom_range(4, 600);
         hh  = ($urandom_range(3) == 0) ? $urandom_range(4, 16383) : $urandom_range(4, 600);
         cx  = int'($urandom_range(65535 - 2 * hw)) - 32768 + hw;
         cz  = int'($urandom_range(65535 - 2 * hh)) - 32768 + hh;
         wid = 2 * hw;
         hgt = 2 * hh;
         per = 2 * wid + 2 * hgt;
         stride = per / n;
         rev = $urandom_range(1);
         for (j = 0; j < n; j++) begin
            pos = (rev ? n - 1 - j : j) * stride + int'($urandom_range(stride - 1));
            if (pos < wid) begin
               px = cx - hw + pos;
               pz = cz - hh;
            end else if (pos < wid + hgt) begin
               px = cx + hw;
               pz = cz - hh + (pos - wid);
            end else if (pos < 2 * wid + hgt) begin
               px = cx + hw - (pos - wid - hgt);
               pz = cz + hh;
            end else begin
               px = cx - hw;
               pz = cz + hh - (pos - 2 * wid - hgt);
            end
            send_item(OP_WRITE, IDX_W'(j), to_coord(px), to_coord(pz), CHECK_PREDICTED);
         end

         len = $urandom_range(40, 120);
         mx  = hw / 4 + 1;
         mz  = hh / 4 + 1;
         for (q = 0; q < len; q++) begin
            if (items_sent >= base + ITEM_TARGET - QUIET_ITEMS) begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            r = $urandom_range(99);
            if (r < 75) begin
               px = cx - hw - mx + int'($urandom_range(2 * hw + 2 * mx));
               pz = cz - hh - mz + int'($urandom_range(2 * hh + 2 * mz));
               send_item(OP_QUERY, IDX_W'($urandom_range(15)), to_coord(px), to_coord(pz),
                         CHECK_PREDICTED);
            end else if (r < 85) begin
               send_item(OP_QUERY, IDX_W'($urandom_range(15)), COORD_W'($urandom),
                         COORD_W'($urandom), CHECK_PREDICTED);
            end else if (r < 92) begin
               j = $urandom_range(n - 1);
               send_item(OP_QUERY, IDX_W'($urandom_range(15)), vertex_x[j], vertex_z[j],
                         CHECK_PREDICTED);
            end else begin
               send_item(OP_WRITE, IDX_W'($urandom_range(15)), COORD_W'($urandom),
                         COORD_W'($urandom), CHECK_PREDICTED);
            end
            if ($urandom_range(99) < 2 || (phase == 3 && q == len / 2)) drain();
         end
         phase++;
      end

      drain();
      if (errors == 0)
         $display("[point_in_convex_polygon_unit] OK");
      else
         $display("[point_in_convex_polygon_unit] ERROR");
      $finish;
   end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/pic_pkg.sv
hw/rtl/pic_req_if.sv
hw/rtl/pic_rsp_if.sv
hw/rtl/pic_ram.sv
hw/rtl/pic_ctrl.sv
hw/rtl/pic_datapath.sv
hw/rtl/point_in_convex_polygon_unit.sv
hw/rtl/pic_checker.sv
sim/point_in_convex_polygon_unit_tb.sv
